// ===== rtl/core/cds_pkg.sv =====
// cds_pkg: types, constants and calendar helper functions for the date stepper
// used by the channel interfaces, the controller, the datapath and the top level
package cds_pkg;

   localparam int CMD_W   = 2;
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int COUNT_W = 16;

   localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;
   localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd1;
   localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2000;

   localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
   localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
   localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;
   localparam logic [DAY_W-1:0]   FIRST_DAY = 5'd1;
   localparam logic [DAY_W-1:0]   DEC_DAYS  = 5'd31;
   localparam logic [DAY_W-1:0]   FEB_LEAP  = 5'd29;
   localparam logic [DAY_W-1:0]   FEB_PLAIN = 5'd28;

   localparam logic [DAY_W-1:0] MONTH_LEN [0:12] = '{
      5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   // two-digit year mapping
   localparam logic [YEAR_W-1:0] PIVOT_YEAR   = 14'd50;
   localparam logic [YEAR_W-1:0] CENTURY_SPAN = 14'd100;
   localparam logic [YEAR_W-1:0] BASE_2000    = 14'd2000;
   localparam logic [YEAR_W-1:0] BASE_1900    = 14'd1900;

   // 25 * 7209 = 1 mod 2^14, so y is a multiple of 25 iff y*7209 mod 2^14 <= 16383/25
   localparam logic [YEAR_W-1:0] INV_25     = 14'd7209;
   localparam logic [YEAR_W-1:0] DIV_25_MAX = 14'd655;

   localparam logic [COUNT_W-1:0] MAX_DAYS = 16'hFFFF;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD    = 2'd0,
      CMD_ADVANCE = 2'd1,
      CMD_BACK    = 2'd2,
      CMD_COUNT   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_STEP,
      ST_COUNT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic load_date;
      logic step_fwd;
      logic step_back;
      logic commit;
      logic count_pass;
      logic count_fail;
      logic emit;
   } ctrl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    steps_done;
      logic    tgt_valid;
      logic    tgt_hit;
      logic    limit_hit;
      logic    rsp_free;
   } stat_type;

   // 400/100/4 rule: leap iff divisible by 4 and (not by 100, or by 400)
   function automatic logic is_leap(input logic [YEAR_W-1:0] year);
      logic [YEAR_W-1:0] prod;
      logic              by_25;
      prod  = YEAR_W'(year * INV_25);
      by_25 = (prod <= DIV_25_MAX);
      return (year[1:0] == 2'b00) && (!by_25 || (year[3:2] == 2'b00));
   endfunction

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      if (month > DECEMBER) begin
         len = '0;
      end else if (month == FEBRUARY) begin
         len = leap ? FEB_LEAP : FEB_PLAIN;
      end else begin
         len = MONTH_LEN[month];
      end
      return len;
   endfunction

   function automatic logic [YEAR_W-1:0] map_year(input logic [YEAR_W-1:0] year);
      logic [YEAR_W-1:0] mapped;
      if (year < PIVOT_YEAR) begin
         mapped = year + BASE_2000;
      end else if (year < CENTURY_SPAN) begin
         mapped = year + BASE_1900;
      end else begin
         mapped = year;
      end
      return mapped;
   endfunction

endpackage

// ===== rtl/core/cds_if.sv =====
// cds_if: request and response channel interfaces of the date stepper
// depends on cds_pkg for the field widths
interface cds_req_if import cds_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [DAY_W-1:0]   in_day;
   logic [MONTH_W-1:0] in_month;
   logic [YEAR_W-1:0]  in_year;
   logic [COUNT_W-1:0] step_count;

   modport source (output valid, cmd, in_day, in_month, in_year, step_count,
                   input ready);
   modport sink (input valid, cmd, in_day, in_month, in_year, step_count,
                 output ready);
endinterface

interface cds_rsp_if import cds_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [DAY_W-1:0]   out_day;
   logic [MONTH_W-1:0] out_month;
   logic [YEAR_W-1:0]  out_year;
   logic               leap_flag;
   logic               is_before;
   logic               is_after;
   logic [COUNT_W-1:0] days_between;
   logic               status;

   modport source (output valid, out_day, out_month, out_year, leap_flag, is_before,
                   is_after, days_between, status,
                   input ready);
   modport sink (input valid, out_day, out_month, out_year, leap_flag, is_before,
                 is_after, days_between, status,
                 output ready);
endinterface

// ===== rtl/core/calendar_date_stepper.sv =====
// Gregorian date stepper: one held date (reset 2000-01-01) with load, advance, go back
// and count-to-date commands, one response per request. Count-to-date walks forward to
// the target; it fails without stepping for a target that is not a real date, and fails
// once COUNT_LIMIT days have been stepped when the target is out of reach. The
// working-date register steps one calendar day per cycle. A new request is accepted as
// soon as the previous response sits in the output register.
module calendar_date_stepper import cds_pkg::*; #(
   parameter int unsigned COUNT_LIMIT = 65535
) (
   input logic       clock,
   input logic       reset,
   cds_req_if.sink   req_chan,
   cds_rsp_if.source rsp_chan
);

   ctrl_type ctrl;
   stat_type sts;
   logic     req_ready;

   cds_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctrl      (ctrl)
   );

   cds_datapath #(
      .COUNT_LIMIT (COUNT_LIMIT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_cmd        (req_chan.cmd),
      .req_day        (req_chan.in_day),
      .req_month      (req_chan.in_month),
      .req_year       (req_chan.in_year),
      .req_step_count (req_chan.step_count),
      .ctrl           (ctrl),
      .sts            (sts),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_day        (rsp_chan.out_day),
      .rsp_month      (rsp_chan.out_month),
      .rsp_year       (rsp_chan.out_year),
      .rsp_leap       (rsp_chan.leap_flag),
      .rsp_before     (rsp_chan.is_before),
      .rsp_after      (rsp_chan.is_after),
      .rsp_between    (rsp_chan.days_between),
      .rsp_status     (rsp_chan.status)
   );

   assign req_chan.ready = req_ready;

endmodule

// ===== rtl/core/cds_controller.sv =====
// cds_controller: command sequencer of the date stepper
// depends on cds_pkg for state, command and control/status struct types
module cds_controller import cds_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type sts,
   output ctrl_type ctrl
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.capture = 1'b1;
               state_in     = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (sts.cmd)
               CMD_LOAD: begin
                  ctrl.load_date = 1'b1;
                  state_in       = ST_FINISH;
               end
               CMD_ADVANCE, CMD_BACK: begin
                  state_in = ST_STEP;
               end
               CMD_COUNT: begin
                  state_in = ST_COUNT;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_STEP: begin
            if (sts.steps_done) begin
               ctrl.commit = 1'b1;
               state_in    = ST_FINISH;
            end else if (sts.cmd == CMD_BACK) begin
               ctrl.step_back = 1'b1;
            end else begin
               ctrl.step_fwd = 1'b1;
            end
         end
         ST_COUNT: begin
            // invalid target is never reached
            if (!sts.tgt_valid) begin
               ctrl.count_fail = 1'b1;
               state_in        = ST_FINISH;
            end else if (sts.tgt_hit) begin
               ctrl.count_pass = 1'b1;
               state_in        = ST_FINISH;
            end else if (sts.limit_hit) begin
               ctrl.count_fail = 1'b1;
               state_in        = ST_FINISH;
            end else begin
               ctrl.step_fwd = 1'b1;
            end
         end
         ST_FINISH: begin
            if (sts.rsp_free) begin
               ctrl.emit = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_emit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> sts.rsp_free)
      else $error("result emitted while output register is occupied");

   a_capture_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.capture |=> (state_ff == ST_DISPATCH))
      else $error("accepted request did not move to dispatch");

   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.step_fwd, ctrl.step_back, ctrl.count_pass, ctrl.count_fail,
                ctrl.commit, ctrl.load_date}))
      else $error("conflicting datapath actions in one cycle");

endmodule

// ===== rtl/core/cds_datapath.sv =====
// cds_datapath: held date, working date stepper, target compare and output register
// depends on cds_pkg for widths, calendar functions and control/status structs
module cds_datapath import cds_pkg::*; #(
   parameter int unsigned COUNT_LIMIT = 65535
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [DAY_W-1:0]   req_day,
   input  logic [MONTH_W-1:0] req_month,
   input  logic [YEAR_W-1:0]  req_year,
   input  logic [COUNT_W-1:0] req_step_count,
   input  ctrl_type           ctrl,
   output stat_type           sts,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [DAY_W-1:0]   rsp_day,
   output logic [MONTH_W-1:0] rsp_month,
   output logic [YEAR_W-1:0]  rsp_year,
   output logic               rsp_leap,
   output logic               rsp_before,
   output logic               rsp_after,
   output logic [COUNT_W-1:0] rsp_between,
   output logic               rsp_status
);

   localparam int CNT_W = $clog2(COUNT_LIMIT) + 1;
   localparam int EXT_W = CNT_W + COUNT_W;
   localparam logic [CNT_W-1:0] LIMIT_VAL = CNT_W'(COUNT_LIMIT);

   cmd_type            cmd_ff, cmd_in;
   logic [DAY_W-1:0]   tgt_day_ff, tgt_day_in;
   logic [MONTH_W-1:0] tgt_month_ff, tgt_month_in;
   logic [YEAR_W-1:0]  tgt_year_ff, tgt_year_in;
   logic [COUNT_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [DAY_W-1:0]   work_day_ff, work_day_in;
   logic [MONTH_W-1:0] work_month_ff, work_month_in;
   logic [YEAR_W-1:0]  work_year_ff, work_year_in;
   logic [DAY_W-1:0]   held_day_ff, held_day_in;
   logic [MONTH_W-1:0] held_month_ff, held_month_in;
   logic [YEAR_W-1:0]  held_year_ff, held_year_in;
   logic [COUNT_W-1:0] between_ff, between_in;
   logic               status_ff, status_in;
   logic               out_valid_ff, out_valid_in;
   logic [DAY_W-1:0]   out_day_ff, out_day_in;
   logic [MONTH_W-1:0] out_month_ff, out_month_in;
   logic [YEAR_W-1:0]  out_year_ff, out_year_in;
   logic               out_leap_ff, out_leap_in;
   logic               out_before_ff, out_before_in;
   logic               out_after_ff, out_after_in;
   logic [COUNT_W-1:0] out_between_ff, out_between_in;
   logic               out_status_ff, out_status_in;

   // calendar logic
   logic               work_leap, tgt_leap, held_leap;
   logic [DAY_W-1:0]   work_len, prev_len, tgt_len, load_len;
   logic [MONTH_W-1:0] load_month;
   logic [DAY_W-1:0]   load_day;
   logic [DAY_W-1:0]   fwd_day, back_day;
   logic [MONTH_W-1:0] fwd_month, back_month;
   logic [YEAR_W-1:0]  fwd_year, back_year;
   logic [DAY_W+MONTH_W+YEAR_W-1:0] held_key, tgt_key, work_key;
   logic [EXT_W-1:0]   count_ext;
   logic [COUNT_W-1:0] count_sat;

   assign work_leap = is_leap(work_year_ff);
   assign tgt_leap  = is_leap(tgt_year_ff);
   assign held_leap = is_leap(held_year_ff);
   assign work_len  = month_days(work_month_ff, work_leap);
   assign prev_len  = month_days(work_month_ff - MONTH_W'(1), work_leap);
   assign tgt_len   = month_days(tgt_month_ff, tgt_leap);

   // one day forward
   always_comb begin
      fwd_day   = work_day_ff + DAY_W'(1);
      fwd_month = work_month_ff;
      fwd_year  = work_year_ff;
      if (work_day_ff >= work_len) begin
         fwd_day = FIRST_DAY;
         if (work_month_ff >= DECEMBER) begin
            fwd_month = JANUARY;
            fwd_year  = work_year_ff + YEAR_W'(1);
         end else begin
            fwd_month = work_month_ff + MONTH_W'(1);
         end
      end
   end

   // one day back
   always_comb begin
      back_day   = work_day_ff - DAY_W'(1);
      back_month = work_month_ff;
      back_year  = work_year_ff;
      if (work_day_ff <= FIRST_DAY) begin
         if (work_month_ff > JANUARY) begin
            back_month = work_month_ff - MONTH_W'(1);
            back_day   = prev_len;
         end else begin
            back_month = DECEMBER;
            back_year  = work_year_ff - YEAR_W'(1);
            back_day   = DEC_DAYS;
         end
      end
   end

   // clamp the loaded date to a real calendar date
   always_comb begin
      if (tgt_month_ff < JANUARY) begin
         load_month = JANUARY;
      end else if (tgt_month_ff > DECEMBER) begin
         load_month = DECEMBER;
      end else begin
         load_month = tgt_month_ff;
      end
      load_len = month_days(load_month, tgt_leap);
      if (tgt_day_ff < FIRST_DAY) begin
         load_day = FIRST_DAY;
      end else if (tgt_day_ff > load_len) begin
         load_day = load_len;
      end else begin
         load_day = tgt_day_ff;
      end
   end

   assign held_key  = {held_year_ff, held_month_ff, held_day_ff};
   assign tgt_key   = {tgt_year_ff, tgt_month_ff, tgt_day_ff};
   assign work_key  = {work_year_ff, work_month_ff, work_day_ff};
   assign count_ext = EXT_W'(count_ff);
   assign count_sat = (count_ext > EXT_W'(MAX_DAYS)) ? MAX_DAYS : count_ext[COUNT_W-1:0];

   assign sts.cmd        = cmd_ff;
   assign sts.steps_done = (left_ff == '0);
   assign sts.tgt_valid  = (tgt_month_ff >= JANUARY) && (tgt_month_ff <= DECEMBER) &&
                           (tgt_day_ff >= FIRST_DAY) && (tgt_day_ff <= tgt_len);
   assign sts.tgt_hit    = (work_key == tgt_key);
   assign sts.limit_hit  = (count_ff == LIMIT_VAL);
   assign sts.rsp_free   = !out_valid_ff || rsp_ready;

   always_comb begin
      cmd_in        = cmd_ff;
      tgt_day_in    = tgt_day_ff;
      tgt_month_in  = tgt_month_ff;
      tgt_year_in   = tgt_year_ff;
      left_in       = left_ff;
      count_in      = count_ff;
      work_day_in   = work_day_ff;
      work_month_in = work_month_ff;
      work_year_in  = work_year_ff;
      held_day_in   = held_day_ff;
      held_month_in = held_month_ff;
      held_year_in  = held_year_ff;
      between_in    = between_ff;
      status_in     = status_ff;
      if (ctrl.capture) begin
         cmd_in        = cmd_type'(req_cmd);
         tgt_day_in    = req_day;
         tgt_month_in  = req_month;
         tgt_year_in   = map_year(req_year);
         left_in       = req_step_count;
         count_in      = '0;
         work_day_in   = held_day_ff;
         work_month_in = held_month_ff;
         work_year_in  = held_year_ff;
         between_in    = '0;
         status_in     = 1'b0;
      end
      if (ctrl.step_fwd || ctrl.step_back) begin
         left_in  = left_ff - COUNT_W'(1);
         count_in = count_ff + CNT_W'(1);
      end
      if (ctrl.step_fwd) begin
         work_day_in   = fwd_day;
         work_month_in = fwd_month;
         work_year_in  = fwd_year;
      end else if (ctrl.step_back) begin
         work_day_in   = back_day;
         work_month_in = back_month;
         work_year_in  = back_year;
      end
      if (ctrl.load_date) begin
         held_day_in   = load_day;
         held_month_in = load_month;
         held_year_in  = tgt_year_ff;
      end else if (ctrl.commit) begin
         held_day_in   = work_day_ff;
         held_month_in = work_month_ff;
         held_year_in  = work_year_ff;
      end
      if (ctrl.count_pass) begin
         between_in = count_sat;
      end
      if (ctrl.count_fail) begin
         status_in = 1'b1;
      end
   end

   // output register
   always_comb begin
      out_valid_in   = out_valid_ff;
      out_day_in     = out_day_ff;
      out_month_in   = out_month_ff;
      out_year_in    = out_year_ff;
      out_leap_in    = out_leap_ff;
      out_before_in  = out_before_ff;
      out_after_in   = out_after_ff;
      out_between_in = out_between_ff;
      out_status_in  = out_status_ff;
      if (ctrl.emit) begin
         out_valid_in   = 1'b1;
         out_day_in     = held_day_ff;
         out_month_in   = held_month_ff;
         out_year_in    = held_year_ff;
         out_leap_in    = held_leap;
         out_before_in  = (held_key < tgt_key);
         out_after_in   = (held_key > tgt_key);
         out_between_in = between_ff;
         out_status_in  = status_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_day_ff   <= RESET_DAY;
         held_month_ff <= RESET_MONTH;
         held_year_ff  <= RESET_YEAR;
         out_valid_ff  <= 1'b0;
      end else begin
         held_day_ff   <= held_day_in;
         held_month_ff <= held_month_in;
         held_year_ff  <= held_year_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      tgt_day_ff     <= tgt_day_in;
      tgt_month_ff   <= tgt_month_in;
      tgt_year_ff    <= tgt_year_in;
      left_ff        <= left_in;
      count_ff       <= count_in;
      work_day_ff    <= work_day_in;
      work_month_ff  <= work_month_in;
      work_year_ff   <= work_year_in;
      between_ff     <= between_in;
      status_ff      <= status_in;
      out_day_ff     <= out_day_in;
      out_month_ff   <= out_month_in;
      out_year_ff    <= out_year_in;
      out_leap_ff    <= out_leap_in;
      out_before_ff  <= out_before_in;
      out_after_ff   <= out_after_in;
      out_between_ff <= out_between_in;
      out_status_ff  <= out_status_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_day     = out_day_ff;
   assign rsp_month   = out_month_ff;
   assign rsp_year    = out_year_ff;
   assign rsp_leap    = out_leap_ff;
   assign rsp_before  = out_before_ff;
   assign rsp_after   = out_after_ff;
   assign rsp_between = out_between_ff;
   assign rsp_status  = out_status_ff;

   a_held_date_valid: assert property (@(posedge clock) disable iff (reset)
      (held_month_ff >= JANUARY) && (held_month_ff <= DECEMBER) &&
      (held_day_ff >= FIRST_DAY) && (held_day_ff <= month_days(held_month_ff, held_leap)))
      else $error("held date is not a calendar date");

   a_work_date_valid: assert property (@(posedge clock) disable iff (reset)
      (ctrl.step_fwd || ctrl.step_back || ctrl.commit) |->
      ((work_day_ff >= FIRST_DAY) && (work_day_ff <= work_len)))
      else $error("working date left the calendar");

   a_fail_has_no_distance: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_status_ff) |-> (out_between_ff == '0))
      else $error("failed count reports a nonzero distance");

endmodule
